// ----- rtl/boat_pkg.sv -----
// Shared types, constants and codes of the buffer occupancy autotuner.
package boat_pkg;

    // Field widths of the request and result channels.
    localparam int OCC_W      = 16;
    localparam int CAP_W      = 16;
    localparam int WK_W       = 8;
    localparam int PCT_W      = 7;
    localparam int DEV_W      = 6;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Default depth of the sample statistics.
    localparam int MAX_SAMPLES_DEF = 1023;

    // Decision thresholds, all in percent except the sample minimum.
    localparam int MIN_TUNE_SAMPLES = 10;
    localparam int STOP_MEAN        = 80;
    localparam int LOW_MEAN         = 30;
    localparam int DEV_LIMIT        = 20;
    localparam int PCT_FULL         = 100;

    // Register reset values.
    localparam logic [CAP_W-1:0] INIT_CAP_RST = 16'd64;
    localparam logic [CAP_W-1:0] MAX_CAP_RST  = 16'd1024;
    localparam logic [CAP_W-1:0] STEP_RST     = 16'd1;
    localparam logic [WK_W-1:0]  INIT_WK_RST  = 8'd1;
    localparam logic [WK_W-1:0]  MAX_WK_RST   = 8'd16;
    localparam logic             BUF_EN_RST   = 1'b1;
    localparam logic             WK_EN_RST    = 1'b1;

    // Request kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TUNE   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_CAP = 3'd0,
        REG_MAX_CAP  = 3'd1,
        REG_STEP     = 3'd2,
        REG_INIT_WK  = 3'd3,
        REG_MAX_WK   = 3'd4,
        REG_BUF_EN   = 3'd5,
        REG_WK_EN    = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        ACT_TAKEN    = 3'd0,
        ACT_DROPPED  = 3'd1,
        ACT_FEW      = 3'd2,
        ACT_STOPPED  = 3'd3,
        ACT_WK_UP    = 3'd4,
        ACT_WK_HELD  = 3'd5,
        ACT_BUF_UP   = 3'd6,
        ACT_BUF_HELD = 3'd7
    } action_t;

    typedef struct packed {
        logic             kind;
        logic [OCC_W-1:0] occupancy;
    } in_item_t;

    typedef struct packed {
        action_t          action;
        logic [PCT_W-1:0] mean_usage;
        logic [DEV_W-1:0] usage_deviation;
        logic [CAP_W-1:0] buffer_capacity;
        logic [WK_W-1:0]  worker_count;
        logic             buffer_tuning_on;
        logic             worker_tuning_on;
    } out_item_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

endpackage

// ----- rtl/boat_alu.sv -----
// Shared arithmetic unit: registered multiply, bit-serial divide and integer square root.
module boat_alu #(
    parameter int OPA_W = 34,
    parameter int MUL_W = 24,
    parameter int DVD_W = 23,
    parameter int DVS_W = 16,
    parameter int SQI_W = 34
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  boat_pkg::alu_req_t   req,
    input  logic [OPA_W-1:0]     opa,
    input  logic [MUL_W-1:0]     opb,
    output boat_pkg::alu_rsp_t   rsp,
    output logic [OPA_W-1:0]     result
);

    localparam int RT_W   = SQI_W / 2;
    localparam int CMP_W  = (DVS_W + 1 > RT_W + 3) ? DVS_W + 1 : RT_W + 3;
    localparam int ITER_N = (DVD_W > RT_W) ? DVD_W : RT_W;
    localparam int ITER_W = $clog2(ITER_N + 1);

    logic                busy_reg;
    logic                done_reg;
    boat_pkg::alu_op_t   op_reg;
    logic [ITER_W-1:0]   cnt_reg;
    logic [CMP_W-1:0]    rem_reg;
    logic [OPA_W-1:0]    shf_reg;
    logic [RT_W-1:0]     root_reg;
    logic [DVS_W-1:0]    dvs_reg;
    logic [OPA_W-1:0]    mul_reg;

    logic [CMP_W-1:0]    cmp_x;
    logic [CMP_W-1:0]    cmp_y;
    logic [CMP_W-1:0]    diff;
    logic                ge;
    logic [2*MUL_W-1:0]  prod;

    assign prod = opa[MUL_W-1:0] * opb;

    // One compare and subtract serves both the divide and the root step.
    always_comb begin
        if (op_reg == boat_pkg::ALU_DIV) begin
            cmp_x = CMP_W'({rem_reg[DVS_W-1:0], shf_reg[DVD_W-1]});
            cmp_y = CMP_W'(dvs_reg);
        end else begin
            cmp_x = CMP_W'({rem_reg[RT_W:0], shf_reg[SQI_W-1 -: 2]});
            cmp_y = CMP_W'({root_reg, 2'b01});
        end
        ge   = (cmp_x >= cmp_y);
        diff = cmp_x - cmp_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= boat_pkg::ALU_MUL;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                op_reg <= req.op;
                case (req.op)
                    boat_pkg::ALU_MUL: begin
                        mul_reg  <= prod[OPA_W-1:0];
                        done_reg <= 1'b1;
                    end
                    boat_pkg::ALU_DIV: begin
                        shf_reg  <= OPA_W'(opa[DVD_W-1:0]);
                        dvs_reg  <= opb[DVS_W-1:0];
                        rem_reg  <= '0;
                        cnt_reg  <= ITER_W'(DVD_W);
                        busy_reg <= 1'b1;
                    end
                    boat_pkg::ALU_SQRT: begin
                        shf_reg  <= opa;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= ITER_W'(RT_W);
                        busy_reg <= 1'b1;
                    end
                    default: begin
                        done_reg <= 1'b1;
                    end
                endcase
            end else if (busy_reg) begin
                rem_reg <= ge ? diff : cmp_x;
                if (op_reg == boat_pkg::ALU_DIV) begin
                    shf_reg <= {shf_reg[OPA_W-2:0], ge};
                end else begin
                    shf_reg  <= {shf_reg[OPA_W-3:0], 2'b00};
                    root_reg <= {root_reg[RT_W-2:0], ge};
                end
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (op_reg)
            boat_pkg::ALU_DIV:  result = OPA_W'(shf_reg[DVD_W-1:0]);
            boat_pkg::ALU_SQRT: result = OPA_W'(root_reg);
            default:            result = mul_reg;
        endcase
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

endmodule

// ----- rtl/buffer_occupancy_autotuner.sv -----
// Top level of the buffer occupancy autotuner: sequencer, statistics and tuning decision.
//
// The block takes one request at a time and is not ready while it works on one. An
// occupancy sample has its usage percentage computed by a 23-step bit-serial divide in the
// shared arithmetic unit, followed by one multiply for its square. At zero working capacity
// the divide is skipped. A tune request with enough samples runs two multiplies, a square
// root of (CNT_W + 7) steps and two 23-step divides, all on the same shared unit, each with
// a launch state and a wait state, and then a decision state, where CNT_W is the width of
// the sample counter (10 at the default depth of 1023 samples). A dropped sample or a tune
// request with too few samples goes straight from acceptance to the output state. The
// result sits in an output register, so the next request is accepted as soon as the
// sequencer is back in its idle state, even while the previous result waits to be taken.
// Any configuration write to a known register reloads the working capacity, worker count and
// both growth enables from the registers; the collected statistics are kept.
module buffer_occupancy_autotuner #(
    parameter int MAX_SAMPLES = boat_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  boat_pkg::in_item_t                  s_item,

    output logic                                m_valid,
    input  logic                                m_ready,
    output boat_pkg::out_item_t                 m_item,

    input  logic                                cfg_wr_en,
    input  logic [boat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [boat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CAP_W = boat_pkg::CAP_W;
    localparam int WK_W  = boat_pkg::WK_W;
    localparam int PCT_W = boat_pkg::PCT_W;
    localparam int DEV_W = boat_pkg::DEV_W;

    // Statistics widths follow from the sample limit: each percentage is at most 100 (7 bits)
    // and its square at most 10000 (14 bits).
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = CNT_W + PCT_W;
    localparam int SQ_W    = CNT_W + 2 * PCT_W;
    localparam int VAR_W   = 2 * CNT_W + 2 * PCT_W;
    localparam int RT_W    = VAR_W / 2;
    localparam int OCCX_W  = boat_pkg::OCC_W + PCT_W;
    localparam int DVD_W   = (OCCX_W > RT_W) ? OCCX_W : RT_W;
    localparam int DVS_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int OPA_W   = (VAR_W > DVD_W) ? VAR_W : DVD_W;
    localparam int MUL_W   = SQ_W;

    // One-hot sequencer states.
    typedef enum logic [16:0] {
        ST_IDLE      = 17'h00001,
        ST_PCT_GO    = 17'h00002,
        ST_PCT_WAIT  = 17'h00004,
        ST_SQ_GO     = 17'h00008,
        ST_SQ_WAIT   = 17'h00010,
        ST_NSQ_GO    = 17'h00020,
        ST_NSQ_WAIT  = 17'h00040,
        ST_SS_GO     = 17'h00080,
        ST_SS_WAIT   = 17'h00100,
        ST_ROOT_GO   = 17'h00200,
        ST_ROOT_WAIT = 17'h00400,
        ST_DEV_GO    = 17'h00800,
        ST_DEV_WAIT  = 17'h01000,
        ST_MEAN_GO   = 17'h02000,
        ST_MEAN_WAIT = 17'h04000,
        ST_DECIDE    = 17'h08000,
        ST_OUT       = 17'h10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers and working values.
    logic [CAP_W-1:0] init_cap_reg, init_cap_next;
    logic [CAP_W-1:0] max_cap_reg,  max_cap_next;
    logic [CAP_W-1:0] step_reg,     step_next;
    logic [WK_W-1:0]  init_wk_reg,  init_wk_next;
    logic [WK_W-1:0]  max_wk_reg,   max_wk_next;
    logic             buf_en_reg,   buf_en_next;
    logic             wk_en_reg,    wk_en_next;
    logic             cfg_hit;

    logic [CAP_W-1:0] cap_reg;
    logic [WK_W-1:0]  wk_reg;
    logic             buf_on_reg;
    logic             wk_on_reg;

    // Running statistics.
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]  sq_reg;

    // Per-request working registers.
    logic [boat_pkg::OCC_W-1:0] occ_reg;
    logic [PCT_W-1:0]           pct_reg;
    logic [VAR_W-1:0]           acc_reg;
    logic [PCT_W-1:0]           mean_reg;
    logic [DEV_W-1:0]           dev_reg;
    boat_pkg::action_t          act_reg;

    // Output register.
    logic                  m_valid_reg;
    boat_pkg::out_item_t   m_item_reg;

    // Shared arithmetic unit.
    boat_pkg::alu_req_t    alu_req;
    boat_pkg::alu_rsp_t    alu_rsp;
    logic [OPA_W-1:0]      alu_opa;
    logic [MUL_W-1:0]      alu_opb;
    logic [OPA_W-1:0]      alu_result;

    logic                  s_fire;
    logic                  out_load;
    logic                  cnt_full;
    logic                  cnt_few;
    logic [OCCX_W-1:0]     occ_x100;
    logic [VAR_W-1:0]      ss_val;

    // Tuning decision.
    boat_pkg::action_t     act_dec;
    logic [CAP_W-1:0]      cap_dec;
    logic [WK_W-1:0]       wk_dec;
    logic                  buf_on_dec;
    logic                  wk_on_dec;
    logic [CAP_W:0]        cap_sum;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign cnt_full = (cnt_reg >= CNT_W'(MAX_SAMPLES));
    assign cnt_few  = (cnt_reg < CNT_W'(boat_pkg::MIN_TUNE_SAMPLES));
    assign occ_x100 = OCCX_W'(occ_reg) * OCCX_W'(boat_pkg::PCT_FULL);
    assign ss_val   = alu_result[VAR_W-1:0];

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    boat_alu #(
        .OPA_W (OPA_W),
        .MUL_W (MUL_W),
        .DVD_W (DVD_W),
        .DVS_W (DVS_W),
        .SQI_W (VAR_W)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    // Configuration decode. A write to an index past the list changes nothing.
    always_comb begin
        init_cap_next = init_cap_reg;
        max_cap_next  = max_cap_reg;
        step_next     = step_reg;
        init_wk_next  = init_wk_reg;
        max_wk_next   = max_wk_reg;
        buf_en_next   = buf_en_reg;
        wk_en_next    = wk_en_reg;
        cfg_hit       = 1'b0;
        if (cfg_wr_en) begin
            cfg_hit = 1'b1;
            case (cfg_index)
                boat_pkg::REG_INIT_CAP: init_cap_next = cfg_wdata[CAP_W-1:0];
                boat_pkg::REG_MAX_CAP:  max_cap_next  = cfg_wdata[CAP_W-1:0];
                boat_pkg::REG_STEP:     step_next     = cfg_wdata[CAP_W-1:0];
                boat_pkg::REG_INIT_WK:  init_wk_next  = cfg_wdata[WK_W-1:0];
                boat_pkg::REG_MAX_WK:   max_wk_next   = cfg_wdata[WK_W-1:0];
                boat_pkg::REG_BUF_EN:   buf_en_next   = cfg_wdata[0];
                boat_pkg::REG_WK_EN:    wk_en_next    = cfg_wdata[0];
                default:                cfg_hit       = 1'b0;
            endcase
        end
    end

    // Tuning decision from the registered mean and deviation.
    always_comb begin
        act_dec    = boat_pkg::ACT_STOPPED;
        cap_dec    = cap_reg;
        wk_dec     = wk_reg;
        buf_on_dec = buf_on_reg;
        wk_on_dec  = wk_on_reg;
        cap_sum    = {1'b0, cap_reg} + {1'b0, step_reg};
        if (mean_reg >= PCT_W'(boat_pkg::STOP_MEAN) && dev_reg <= DEV_W'(boat_pkg::DEV_LIMIT)) begin
            act_dec    = boat_pkg::ACT_STOPPED;
            buf_on_dec = 1'b0;
            wk_on_dec  = 1'b0;
        end else if (mean_reg <= PCT_W'(boat_pkg::LOW_MEAN)
                     || dev_reg <= DEV_W'(boat_pkg::DEV_LIMIT)) begin
            if (wk_on_reg && wk_reg < max_wk_reg) begin
                act_dec = boat_pkg::ACT_WK_UP;
                wk_dec  = wk_reg + WK_W'(1);
            end else begin
                act_dec = boat_pkg::ACT_WK_HELD;
            end
        end else begin
            if (buf_on_reg && cap_reg < max_cap_reg) begin
                act_dec = boat_pkg::ACT_BUF_UP;
                if (cap_sum > {1'b0, max_cap_reg}) begin
                    cap_dec = max_cap_reg;
                end else begin
                    cap_dec = cap_sum[CAP_W-1:0];
                end
            end else begin
                act_dec = boat_pkg::ACT_BUF_HELD;
            end
        end
    end

    // Sequencer. Each unit operation gets a launch state and a wait state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.kind == boat_pkg::KIND_SAMPLE) begin
                        if (cnt_full) begin
                            state_next = ST_OUT;
                        end else if (cap_reg == '0) begin
                            state_next = ST_SQ_GO;
                        end else begin
                            state_next = ST_PCT_GO;
                        end
                    end else if (cnt_few) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_NSQ_GO;
                    end
                end
            end
            ST_PCT_GO:    state_next = ST_PCT_WAIT;
            ST_PCT_WAIT:  if (alu_rsp.done) state_next = ST_SQ_GO;
            ST_SQ_GO:     state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:   if (alu_rsp.done) state_next = ST_OUT;
            ST_NSQ_GO:    state_next = ST_NSQ_WAIT;
            ST_NSQ_WAIT:  if (alu_rsp.done) state_next = ST_SS_GO;
            ST_SS_GO:     state_next = ST_SS_WAIT;
            ST_SS_WAIT:   if (alu_rsp.done) state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (alu_rsp.done) state_next = ST_DEV_GO;
            ST_DEV_GO:    state_next = ST_DEV_WAIT;
            ST_DEV_WAIT:  if (alu_rsp.done) state_next = ST_MEAN_GO;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (alu_rsp.done) state_next = ST_DECIDE;
            ST_DECIDE:    state_next = ST_OUT;
            ST_OUT:       if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared unit.
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = boat_pkg::ALU_MUL;
        alu_opa       = '0;
        alu_opb       = '0;
        case (state_reg)
            ST_PCT_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = boat_pkg::ALU_DIV;
                alu_opa       = OPA_W'(occ_x100);
                alu_opb       = MUL_W'(cap_reg);
            end
            ST_SQ_GO: begin
                alu_req.start = 1'b1;
                alu_opa       = OPA_W'(pct_reg);
                alu_opb       = MUL_W'(pct_reg);
            end
            ST_NSQ_GO: begin
                alu_req.start = 1'b1;
                alu_opa       = OPA_W'(cnt_reg);
                alu_opb       = sq_reg;
            end
            ST_SS_GO: begin
                alu_req.start = 1'b1;
                alu_opa       = OPA_W'(sum_reg);
                alu_opb       = MUL_W'(sum_reg);
            end
            ST_ROOT_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = boat_pkg::ALU_SQRT;
                alu_opa       = OPA_W'(acc_reg);
            end
            ST_DEV_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = boat_pkg::ALU_DIV;
                alu_opa       = OPA_W'(acc_reg[RT_W-1:0]);
                alu_opb       = MUL_W'(cnt_reg);
            end
            ST_MEAN_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = boat_pkg::ALU_DIV;
                alu_opa       = OPA_W'(sum_reg);
                alu_opb       = MUL_W'(cnt_reg);
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    // Control state, configuration, working values and statistics.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            init_cap_reg <= boat_pkg::INIT_CAP_RST;
            max_cap_reg  <= boat_pkg::MAX_CAP_RST;
            step_reg     <= boat_pkg::STEP_RST;
            init_wk_reg  <= boat_pkg::INIT_WK_RST;
            max_wk_reg   <= boat_pkg::MAX_WK_RST;
            buf_en_reg   <= boat_pkg::BUF_EN_RST;
            wk_en_reg    <= boat_pkg::WK_EN_RST;
            cap_reg      <= boat_pkg::INIT_CAP_RST;
            wk_reg       <= boat_pkg::INIT_WK_RST;
            buf_on_reg   <= boat_pkg::BUF_EN_RST;
            wk_on_reg    <= boat_pkg::WK_EN_RST;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_hit) begin
                init_cap_reg <= init_cap_next;
                max_cap_reg  <= max_cap_next;
                step_reg     <= step_next;
                init_wk_reg  <= init_wk_next;
                max_wk_reg   <= max_wk_next;
                buf_en_reg   <= buf_en_next;
                wk_en_reg    <= wk_en_next;
                cap_reg      <= init_cap_next;
                wk_reg       <= init_wk_next;
                buf_on_reg   <= buf_en_next;
                wk_on_reg    <= wk_en_next;
            end else if (state_reg == ST_DECIDE) begin
                cap_reg    <= cap_dec;
                wk_reg     <= wk_dec;
                buf_on_reg <= buf_on_dec;
                wk_on_reg  <= wk_on_dec;
            end

            if (state_reg == ST_SQ_WAIT && alu_rsp.done) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                sum_reg <= sum_reg + SUM_W'(pct_reg);
                sq_reg  <= sq_reg + alu_result[SQ_W-1:0];
            end else if (state_reg == ST_DECIDE) begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end
        end
    end

    // Per-request datapath registers; none of them needs a reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            occ_reg  <= s_item.occupancy;
            mean_reg <= '0;
            dev_reg  <= '0;
            pct_reg  <= PCT_W'(boat_pkg::PCT_FULL);
            if (s_item.kind == boat_pkg::KIND_SAMPLE) begin
                act_reg <= cnt_full ? boat_pkg::ACT_DROPPED : boat_pkg::ACT_TAKEN;
            end else begin
                act_reg <= boat_pkg::ACT_FEW;
            end
        end

        if (alu_rsp.done) begin
            case (state_reg)
                ST_PCT_WAIT: begin
                    // Occupancy above capacity saturates at full usage.
                    if (alu_result > OPA_W'(boat_pkg::PCT_FULL)) begin
                        pct_reg <= PCT_W'(boat_pkg::PCT_FULL);
                    end else begin
                        pct_reg <= alu_result[PCT_W-1:0];
                    end
                end
                ST_NSQ_WAIT:  acc_reg  <= alu_result[VAR_W-1:0];
                ST_SS_WAIT:   acc_reg  <= (acc_reg > ss_val) ? acc_reg - ss_val : '0;
                ST_ROOT_WAIT: acc_reg  <= VAR_W'(alu_result[RT_W-1:0]);
                ST_DEV_WAIT:  dev_reg  <= alu_result[DEV_W-1:0];
                ST_MEAN_WAIT: mean_reg <= alu_result[PCT_W-1:0];
                default:      acc_reg  <= acc_reg;
            endcase
        end

        if (state_reg == ST_DECIDE) begin
            act_reg <= act_dec;
        end

        if (out_load) begin
            m_item_reg.action           <= act_reg;
            m_item_reg.mean_usage       <= mean_reg;
            m_item_reg.usage_deviation  <= dev_reg;
            m_item_reg.buffer_capacity  <= cap_reg;
            m_item_reg.worker_count     <= wk_reg;
            m_item_reg.buffer_tuning_on <= buf_on_reg;
            m_item_reg.worker_tuning_on <= wk_on_reg;
        end
    end

`ifndef SYNTH
    // The sequencer never launches an operation while the unit is still iterating.
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |-> !alu_rsp.busy)
        else $error("arithmetic unit started while busy");

    // The sample counter never passes the configured limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample counter beyond limit");

    // A saturated percentage is what enters the square and the sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ_GO) |-> (pct_reg <= PCT_W'(boat_pkg::PCT_FULL)))
        else $error("usage percentage above full");

    // A completed tune decision leaves the statistics cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_item_reg.action != boat_pkg::ACT_TAKEN
         && m_item_reg.action != boat_pkg::ACT_DROPPED
         && m_item_reg.action != boat_pkg::ACT_FEW) |-> (cnt_reg == '0))
        else $error("statistics not cleared after tuning");

    // Buffer growth never goes past the configured maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_item_reg.action == boat_pkg::ACT_BUF_UP)
        |-> (m_item_reg.buffer_capacity <= max_cap_reg))
        else $error("buffer capacity grown past maximum");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the buffer occupancy autotuner with a built-in decision predictor.
`timescale 1ns / 100ps

import boat_pkg::*;

class autotune_tracker;
    logic [CAP_W-1:0] init_cap, max_cap, cap_step;
    logic [WK_W-1:0]  init_wk, max_wk;
    bit               buf_en_reg, wk_en_reg;

    logic [CAP_W-1:0] capacity;
    logic [WK_W-1:0]  workers;
    bit               buffer_growth, worker_growth;
    int unsigned      samples;
    longint unsigned  usage_sum, square_sum;

    out_item_t awaited_status[$];
    int errors, requests, results;
    int outcome_count[8];

    function new();
        init_cap   = INIT_CAP_RST;
        max_cap    = MAX_CAP_RST;
        cap_step   = STEP_RST;
        init_wk    = INIT_WK_RST;
        max_wk     = MAX_WK_RST;
        buf_en_reg = BUF_EN_RST;
        wk_en_reg  = WK_EN_RST;
        reload();
        samples    = 0;
        usage_sum  = 0;
        square_sum = 0;
    endfunction

    function void reload();
        capacity      = init_cap;
        workers       = init_wk;
        buffer_growth = buf_en_reg;
        worker_growth = wk_en_reg;
    endfunction

    // A write to a known register reloads the working values; the statistics stay.
    function void store_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_INIT_CAP: init_cap = data;
            REG_MAX_CAP:  max_cap = data;
            REG_STEP:     cap_step = data;
            REG_INIT_WK:  init_wk = data[WK_W-1:0];
            REG_MAX_WK:   max_wk = data[WK_W-1:0];
            REG_BUF_EN:   buf_en_reg = data[0];
            REG_WK_EN:    wk_en_reg = data[0];
            default:      return;
        endcase
        reload();
    endfunction

    // Builds the root one bit at a time from the top.
    function longint unsigned square_root(longint unsigned v);
        longint unsigned root, probe;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v) root = probe;
        end
        return root;
    endfunction

    function void predict_request(in_item_t req);
        out_item_t       status;
        int unsigned     pct, grown;
        longint unsigned spread, mean, dev;
        status = '0;
        mean = 0;
        dev = 0;
        requests++;
        if (req.kind == KIND_SAMPLE) begin
            if (samples >= MAX_SAMPLES_DEF) begin
                status.action = ACT_DROPPED;
            end else begin
                pct = PCT_FULL;
                if (capacity != 0) begin
                    pct = 32'(req.occupancy) * PCT_FULL / 32'(capacity);
                    if (pct > PCT_FULL) pct = PCT_FULL;
                end
                samples++;
                usage_sum += pct;
                square_sum += pct * pct;
                status.action = ACT_TAKEN;
            end
        end else if (samples < MIN_TUNE_SAMPLES) begin
            status.action = ACT_FEW;
        end else begin
            spread = samples * square_sum;
            if (spread > usage_sum * usage_sum) spread -= usage_sum * usage_sum;
            else spread = 0;
            mean = usage_sum / samples;
            dev = square_root(spread) / samples;
            if (mean >= STOP_MEAN && dev <= DEV_LIMIT) begin
                buffer_growth = 0;
                worker_growth = 0;
                status.action = ACT_STOPPED;
            end else if (mean <= LOW_MEAN || dev <= DEV_LIMIT) begin
                if (worker_growth && workers < max_wk) begin
                    workers++;
                    status.action = ACT_WK_UP;
                end else begin
                    status.action = ACT_WK_HELD;
                end
            end else if (buffer_growth && capacity < max_cap) begin
                grown = capacity + cap_step;
                if (grown > max_cap) grown = max_cap;
                capacity = grown[CAP_W-1:0];
                status.action = ACT_BUF_UP;
            end else begin
                status.action = ACT_BUF_HELD;
            end
            samples = 0;
            usage_sum = 0;
            square_sum = 0;
        end
        status.mean_usage       = mean[PCT_W-1:0];
        status.usage_deviation  = dev[DEV_W-1:0];
        status.buffer_capacity  = capacity;
        status.worker_count     = workers;
        status.buffer_tuning_on = buffer_growth;
        status.worker_tuning_on = worker_growth;
        outcome_count[status.action]++;
        awaited_status.insert(awaited_status.size(), status);
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results, name, got, want));
    endtask

    task check_status(out_item_t got);
        out_item_t want;
        results++;
        if (awaited_status.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none outstanding: %h", results, got));
            return;
        end
        want = awaited_status.pop_front();
        compare_field("action", got.action, want.action);
        compare_field("mean_usage", got.mean_usage, want.mean_usage);
        compare_field("usage_deviation", got.usage_deviation, want.usage_deviation);
        compare_field("buffer_capacity", got.buffer_capacity, want.buffer_capacity);
        compare_field("worker_count", got.worker_count, want.worker_count);
        compare_field("buffer_tuning_on", got.buffer_tuning_on, want.buffer_tuning_on);
        compare_field("worker_tuning_on", got.worker_tuning_on, want.worker_tuning_on);
    endtask
endclass

module testbench;
    // Hard stop for a hung run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Quiet time after the last result, longer than the slowest tune request.
    localparam int DRAIN_CYCLES = 100;
    // An index beyond the register list; writing it must change nothing.
    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX = 3'd7;
    localparam int IDLE_PERCENT = 15;
    localparam int RANDOM_ITEMS = 60;

    // Shapes of occupancy content within one sample run.
    typedef enum int {
        STYLE_HIGH,
        STYLE_LOW,
        STYLE_MID,
        STYLE_SPLIT,
        STYLE_RAW
    } occupancy_style_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // When set, neither side inserts idle cycles.
    bit steady = 1'b0;
    int cycles = 0;

    autotune_tracker tracker = new();

    buffer_occupancy_autotuner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The result side stalls on its own random schedule, independent of the request side.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every accepted result is checked against the oldest prediction. The cycle counter
    // guards against a block that stops answering.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, tracker.awaited_status.size());
            $display("FAIL buffer_occupancy_autotuner");
            $finish;
        end else if (aresetn && m_valid === 1'b1 && m_ready) begin
            tracker.check_status(m_item);
        end
    end

    // Presents one request, possibly after some idle cycles, and holds it until taken.
    // The prediction is made at the edge where the request is accepted. Valid is left high
    // on return, so the next request follows without a gap unless the caller idles.
    task automatic send_request(logic kind, logic [OCC_W-1:0] occ);
        in_item_t req;
        req.kind = kind;
        req.occupancy = occ;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item <= req;
        do @(posedge aclk); while (!s_ready);
        tracker.predict_request(req);
    endtask

    // Picks an occupancy that lands near a chosen usage percentage at the current
    // working capacity, so that each run of samples steers toward one decision.
    function automatic logic [OCC_W-1:0] pick_occupancy(occupancy_style_t style);
        int unsigned cap, pct, occ;
        cap = tracker.capacity;
        case (style)
            STYLE_HIGH:  pct = $urandom_range(85, PCT_FULL);
            STYLE_LOW:   pct = $urandom_range(0, LOW_MEAN);
            STYLE_MID:   pct = $urandom_range(40, 60);
            STYLE_SPLIT: pct = $urandom_range(1) ? $urandom_range(STOP_MEAN, PCT_FULL)
                                                 : $urandom_range(0, DEV_LIMIT);
            default:     return OCC_W'($urandom);
        endcase
        if (cap == 0) return OCC_W'($urandom);
        // Full usage is sometimes reached by an occupancy at or above the capacity.
        if (pct == PCT_FULL && $urandom_range(1)) return OCC_W'($urandom_range(cap, 16'hFFFF));
        occ = pct * cap / PCT_FULL + $urandom_range(0, cap / PCT_FULL);
        if (occ > 16'hFFFF) occ = 16'hFFFF;
        return occ[OCC_W-1:0];
    endfunction

    // Mostly complete sample runs closed by a tune request; the rest are short runs that
    // leave too few samples, and stray requests of either kind with random content.
    task automatic run_random(int count);
        int               stop_at, len, roll;
        occupancy_style_t style;
        stop_at = tracker.requests + count;
        while (tracker.requests < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                style = occupancy_style_t'($urandom_range(STYLE_HIGH, STYLE_RAW));
                len = $urandom_range(MIN_TUNE_SAMPLES, 40);
                repeat (len) send_request(KIND_SAMPLE, pick_occupancy(style));
                send_request(KIND_TUNE, OCC_W'($urandom));
            end else if (roll < 90) begin
                len = $urandom_range(0, MIN_TUNE_SAMPLES - 1);
                repeat (len) send_request(KIND_SAMPLE, OCC_W'($urandom));
                send_request(KIND_TUNE, OCC_W'($urandom));
            end else begin
                send_request(1'($urandom), OCC_W'($urandom));
            end
        end
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (tracker.awaited_status.size() != 0) @(posedge aclk);
    endtask

    // Write enable is left high so that back-to-back writes keep it steady.
    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.store_register(idx, data);
    endtask

    // Writes every register, plus one write to an index past the list, which must be ignored.
    task automatic apply_settings(logic [CFG_DATA_W-1:0] init_cap, max_cap, step,
                                  init_wk, max_wk, buf_en, wk_en);
        write_config(REG_INIT_CAP, init_cap);
        write_config(REG_MAX_CAP, max_cap);
        write_config(REG_STEP, step);
        write_config(REG_INIT_WK, init_wk);
        write_config(REG_MAX_WK, max_wk);
        write_config(UNUSED_INDEX, CFG_DATA_W'($urandom));
        write_config(REG_BUF_EN, buf_en);
        write_config(REG_WK_EN, wk_en);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int settings;
        settings = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings (capacity 64, so occupancy 32 is exactly 50%).
        // A tune with no samples, then one with nine, are both too few.
        send_request(KIND_TUNE, 16'hFFFF);
        repeat (MIN_TUNE_SAMPLES - 1) send_request(KIND_SAMPLE, 16'd32);
        send_request(KIND_TUNE, 16'h0000);
        // The tenth identical sample gives zero deviation, so a worker is added.
        send_request(KIND_SAMPLE, 16'd32);
        send_request(KIND_TUNE, 16'h0000);
        // Empty and saturated samples alternate: mean 50, deviation 50, so the buffer grows.
        for (int i = 0; i < MIN_TUNE_SAMPLES; i++)
            send_request(KIND_SAMPLE, i[0] ? 16'hFFFF : 16'h0000);
        send_request(KIND_TUNE, 16'h0000);

        // Smallest non-zero start capacity with the largest step: the first growth jumps to the top.
        wait_until_idle();
        apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd255, 16'd1, 16'd1);
        run_random(RANDOM_ITEMS);

        // Everything already at its limit and both enables off: only held or stop decisions.
        settings++;
        wait_until_idle();
        apply_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd255, 16'd255, 16'hFFFE, 16'h0000);
        run_random(RANDOM_ITEMS);

        // Zero working capacity counts every sample as full; growth is clamped at a max of one.
        settings++;
        wait_until_idle();
        apply_settings(16'd0, 16'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd0);
        run_random(RANDOM_ITEMS);

        // Overfill the sample store so that the last samples are dropped, then tune on a
        // full store.
        settings++;
        wait_until_idle();
        apply_settings(16'd1000, 16'd4000, 16'd100, 16'd3, 16'd20, 16'd1, 16'd1);
        repeat (MAX_SAMPLES_DEF + 7)
            send_request(KIND_SAMPLE,
                         pick_occupancy(occupancy_style_t'($urandom_range(STYLE_HIGH, STYLE_RAW))));
        send_request(KIND_TUNE, OCC_W'($urandom));
        run_random(RANDOM_ITEMS);

        // Random settings; the upper data bits of the narrow registers carry noise. One of
        // these phases runs without any idling on either side.
        for (int phase = 0; phase < 3; phase++) begin
            settings++;
            wait_until_idle();
            apply_settings(CFG_DATA_W'($urandom_range(1, 16'hFFFF)),
                           CFG_DATA_W'($urandom_range(1, 16'hFFFF)),
                           CFG_DATA_W'($urandom_range(1, 16'hFFFF)),
                           {8'($urandom), 8'($urandom_range(1, 255))},
                           {8'($urandom), 8'($urandom_range(1, 255))},
                           CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            steady = (phase == 1);
            run_random(RANDOM_ITEMS);
            steady = 1'b0;
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.awaited_status.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.awaited_status.size()));

        $display("Covered %0d requests and %0d results over %0d register settings, including",
                 tracker.requests, tracker.results, settings);
        $display("  %0d dropped samples, %0d too-few tunes, stop %0d, workers %0d/%0d, buffer %0d/%0d.",
                 tracker.outcome_count[ACT_DROPPED], tracker.outcome_count[ACT_FEW],
                 tracker.outcome_count[ACT_STOPPED], tracker.outcome_count[ACT_WK_UP],
                 tracker.outcome_count[ACT_WK_HELD], tracker.outcome_count[ACT_BUF_UP],
                 tracker.outcome_count[ACT_BUF_HELD]);
        if (tracker.errors == 0) begin
            $display("PASS buffer_occupancy_autotuner");
        end else begin
            $display("%0d mismatches found.", tracker.errors);
            $display("FAIL buffer_occupancy_autotuner");
        end
        $finish;
    end
endmodule
